[rtl/dmms_pkg.sv]
// Shared types and constants for the display mode match selector.
`timescale 1ns / 1ps

package dmms_pkg;

    // List geometry
    localparam int MAX_MODES = 64;
    localparam int POS_W     = $clog2(MAX_MODES + 1);
    localparam int INDEX_W   = 6;

    // Field widths
    localparam int DIM_W   = 12;
    localparam int SCORE_W = 15;
    localparam int CFG_W   = 12;
    localparam int CIDX_W  = 2;

    // Score values in hundredths
    localparam logic signed [SCORE_W-1:0] SCORE_EXACT      = 15'sd10000;
    localparam logic signed [SCORE_W-1:0] SCORE_DBL_WIDTH  = 15'sd9000;
    localparam logic signed [SCORE_W-1:0] SCORE_DBL_HEIGHT = 15'sd8000;
    localparam logic signed [SCORE_W-1:0] SCORE_DBL_BOTH   = 15'sd7000;
    localparam logic signed [SCORE_W-1:0] SCORE_BASE       = 15'sd5000;
    localparam logic signed [SCORE_W-1:0] SCORE_BONUS      = 15'sd500;
    localparam logic signed [SCORE_W-1:0] SCORE_NONE       = 15'sd0;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TARGET_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TARGET_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VERTICAL_GAME = 2'd2;

    typedef logic signed [SCORE_W-1:0] score_t;

    // Target settings handed to the scorer
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             vertical;
    } target_t;

    // One input word
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             interlaced;
        logic             custom;
        logic             modified;
        logic             last;
    } mode_t;

    // Best candidate kept per category
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        score_t             score;
        logic               custom;
        logic               modified;
    } slot_t;

endpackage

[rtl/dmms_score.sv]
// Combinational score of one candidate mode against the target size.
`timescale 1ns / 1ps

module dmms_score
(
    input  dmms_pkg::target_t             target,
    input  logic [dmms_pkg::DIM_W-1:0]    width,
    input  logic [dmms_pkg::DIM_W-1:0]    height,
    output dmms_pkg::score_t              score
);

    logic [dmms_pkg::DIM_W:0]   tw_dbl;
    logic [dmms_pkg::DIM_W:0]   th_dbl;
    logic                       w_eq;
    logic                       h_eq;
    logic                       w_dbl;
    logic                       h_dbl;
    logic [dmms_pkg::DIM_W-1:0] dw;
    logic [dmms_pkg::DIM_W-1:0] dh;
    dmms_pkg::score_t           partial;

    // Size comparisons
    assign tw_dbl = {target.width, 1'b0};
    assign th_dbl = {target.height, 1'b0};
    assign w_eq   = (width == target.width);
    assign h_eq   = (height == target.height);
    assign w_dbl  = ({1'b0, width} == tw_dbl);
    assign h_dbl  = ({1'b0, height} == th_dbl);
    assign dw     = (width >= target.width) ? (width - target.width) : (target.width - width);
    assign dh     = height - target.height;  // only used when height >= target

    // Base score with bonuses, less the distances
    always_comb
    begin
        partial = dmms_pkg::SCORE_BASE;
        if ((width >= target.width) || target.vertical)
        begin
            partial = partial + dmms_pkg::SCORE_BONUS;
        end
        if (h_eq)
        begin
            partial = partial + dmms_pkg::SCORE_BONUS;
        end
        partial = partial - dmms_pkg::score_t'({3'b000, dw}) - dmms_pkg::score_t'({3'b000, dh});
    end

    // Special sizes take priority
    always_comb
    begin
        priority if (w_eq && h_eq)
        begin
            score = dmms_pkg::SCORE_EXACT;
        end
        else if (w_dbl && h_eq)
        begin
            score = dmms_pkg::SCORE_DBL_WIDTH;
        end
        else if (w_eq && h_dbl)
        begin
            score = dmms_pkg::SCORE_DBL_HEIGHT;
        end
        else if (w_dbl && h_dbl)
        begin
            score = dmms_pkg::SCORE_DBL_BOTH;
        end
        else if (height < target.height)
        begin
            score = dmms_pkg::SCORE_NONE;
        end
        else
        begin
            score = partial;
        end
    end

endmodule

[rtl/display_mode_match_selector.sv]
// Top level: scores display modes and keeps the best per category.
// An accepted mode word passes through the input register, then scoring
// and best-slot update into the result register.
// Throughput: one word per cycle while result_ready does not stall it.
// Reset (rst_n low, async): pipeline empty, slots and position cleared,
// target registers zero.
`timescale 1ns / 1ps

module display_mode_match_selector
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [dmms_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [dmms_pkg::CFG_W-1:0]          cfg_data,

    input  logic                                mode_valid,
    output logic                                mode_ready,
    input  logic [dmms_pkg::DIM_W-1:0]          mode_width,
    input  logic [dmms_pkg::DIM_W-1:0]          mode_height,
    input  logic                                is_interlaced,
    input  logic                                is_custom,
    input  logic                                already_modified,
    input  logic                                last_mode,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [dmms_pkg::SCORE_W-1:0] mode_score,
    output logic                                list_done,
    output logic                                best_found,
    output logic [dmms_pkg::INDEX_W-1:0]        pick_index,
    output logic                                best_apply
);

    dmms_pkg::target_t                target_reg;
    dmms_pkg::mode_t                  in_reg;
    logic                             in_valid_reg;
    logic [dmms_pkg::POS_W-1:0]       position_reg;
    logic [dmms_pkg::POS_W-1:0]       position_next;
    dmms_pkg::slot_t                  il_reg, cu_reg, sy_reg;
    dmms_pkg::slot_t                  il_next, cu_next, sy_next;
    dmms_pkg::slot_t                  il_upd, cu_upd, sy_upd;
    dmms_pkg::slot_t                  cand;
    dmms_pkg::score_t                 score;
    dmms_pkg::score_t                 score_out;
    logic                             list_end;
    logic                             done;
    logic                             take;
    logic                             found;
    logic [dmms_pkg::INDEX_W-1:0]     sel_index;
    logic                             sel_apply;
    logic                             advance;

    dmms_pkg::score_t                 score_reg;
    logic                             done_reg;
    logic                             found_reg;
    logic [dmms_pkg::INDEX_W-1:0]     index_reg;
    logic                             apply_reg;
    logic                             out_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dmms_pkg::CFG_TARGET_WIDTH:  target_reg.width    <= cfg_data;
                dmms_pkg::CFG_TARGET_HEIGHT: target_reg.height   <= cfg_data;
                dmms_pkg::CFG_VERTICAL_GAME: target_reg.vertical <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign mode_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (mode_ready)
        begin
            in_valid_reg <= mode_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mode_valid && mode_ready)
        begin
            in_reg <= '{width: mode_width, height: mode_height, interlaced: is_interlaced,
                        custom: is_custom, modified: already_modified, last: last_mode};
        end
    end

    // Scoring
    dmms_score u_score
    (
        .target (target_reg),
        .width  (in_reg.width),
        .height (in_reg.height),
        .score  (score)
    );

    assign list_end  = (in_reg.width == '0);
    assign done      = list_end || in_reg.last;
    assign score_out = list_end ? dmms_pkg::SCORE_NONE : score;
    assign take      = !list_end && (position_reg < dmms_pkg::POS_W'(dmms_pkg::MAX_MODES));

    assign cand = '{valid: 1'b1, index: dmms_pkg::INDEX_W'(position_reg), score: score,
                    custom: in_reg.custom, modified: in_reg.modified};

    // Category slot update
    always_comb
    begin
        il_upd = il_reg;
        cu_upd = cu_reg;
        sy_upd = sy_reg;
        if (take && (score > dmms_pkg::SCORE_NONE))
        begin
            priority if (!il_reg.valid && in_reg.interlaced)
            begin
                il_upd = cand;
            end
            else if (!cu_reg.valid && in_reg.custom)
            begin
                cu_upd = cand;
            end
            else if (!sy_reg.valid && !in_reg.custom)
            begin
                sy_upd = cand;
            end
            else
            begin
                if (in_reg.custom)
                begin
                    if (score > cu_reg.score)
                    begin
                        cu_upd = cand;
                    end
                end
                else if (score > sy_reg.score)
                begin
                    sy_upd = cand;
                end
                if (in_reg.interlaced && (score > il_reg.score))
                begin
                    il_upd = cand;
                end
            end
        end
    end

    // Final pick by category priority
    always_comb
    begin
        found     = 1'b1;
        sel_index = '0;
        sel_apply = 1'b0;
        priority if (cu_upd.valid)
        begin
            sel_index = cu_upd.index;
            sel_apply = !cu_upd.modified;
        end
        else if (il_upd.valid && il_upd.custom)
        begin
            sel_index = il_upd.index;
            sel_apply = !il_upd.modified;
        end
        else if (sy_upd.valid)
        begin
            sel_index = sy_upd.index;
            sel_apply = !sy_upd.modified;
        end
        else if (il_upd.valid)
        begin
            sel_index = il_upd.index;
            sel_apply = !il_upd.modified;
        end
        else
        begin
            found = 1'b0;
        end
    end

    // Next list state: cleared when the list closes
    always_comb
    begin
        if (done)
        begin
            il_next       = '0;
            cu_next       = '0;
            sy_next       = '0;
            position_next = '0;
        end
        else
        begin
            il_next       = il_upd;
            cu_next       = cu_upd;
            sy_next       = sy_upd;
            position_next = take ? position_reg + 1'b1 : position_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            il_reg       <= '0;
            cu_reg       <= '0;
            sy_reg       <= '0;
            position_reg <= '0;
        end
        else if (advance)
        begin
            il_reg       <= il_next;
            cu_reg       <= cu_next;
            sy_reg       <= sy_next;
            position_reg <= position_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            score_reg <= score_out;
            done_reg  <= done;
            found_reg <= done && found;
            index_reg <= (done && found) ? sel_index : '0;
            apply_reg <= done && found && sel_apply;
        end
    end

    assign result_valid = out_valid_reg;
    assign mode_score   = score_reg;
    assign list_done    = done_reg;
    assign best_found   = found_reg;
    assign pick_index   = index_reg;
    assign best_apply   = apply_reg;

endmodule
